// ===== design/ids_pkg.sv =====
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types and constants for the indexed deque store.
// ----------------------------------------------------------------------------
`default_nettype none

package ids_pkg;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [2:0] {
		KIND_PUSH_BACK  = 3'd0,
		KIND_PUSH_FRONT = 3'd1,
		KIND_POP_BACK   = 3'd2,
		KIND_POP_FRONT  = 3'd3,
		KIND_READ       = 3'd4,
		KIND_WRITE      = 3'd5
	} kind_t;

	typedef struct packed {
		logic               ok;
		logic [DATA_W-1:0]  read_data;
		logic [COUNT_W-1:0] count;
	} result_t;

endpackage

`default_nettype wire

// ===== design/ids_ram.sv =====
// ----------------------------------------------------------------------------
// ids_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ids_ram
	import ids_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [DATA_W-1:0]        wdata,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/indexed_deque_store.sv =====
// ----------------------------------------------------------------------------
// indexed_deque_store
// Bounded deque of signed 32-bit values in a ring buffer, with access at
// both ends and by position; one result beat per request beat.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                  tuser
// s_axis   in   [5:0] position, [37:6] data_in         [2:0] kind
// m_axis   out  [31:0] read_data, [38:32] count        [0] ok
//
// Order: pushes, pops, writes and failed requests load the output register
// directly; a successful read first passes the registered RAM read port.
// Reset: front pointer and fill clear at once; store contents undefined.
// Stalls: a result waits in the output register; a new beat is taken while
// it drains, but not while a RAM read is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_deque_store
	import ids_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,   // position, data_in, zero pad
	input  wire logic [2:0]  s_axis_tuser,   // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [39:0] m_axis_tdata,   // read_data, count, zero pad
	output logic      [0:0]  m_axis_tuser    // ok
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int PW = (AW + 1 > POS_W) ? AW + 1 : POS_W;
	localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
	localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	logic [AW-1:0] front_q;
	logic [FW-1:0] fill_q;
	logic          rd_pend_s1;
	result_t       out_q;
	logic          out_valid_q;

	kind_t              kind;
	logic [POS_W-1:0]   position;
	logic [DATA_W-1:0]  data_in;
	logic [PW-1:0]      pos_p;
	logic [PW-1:0]      fill_p;
	logic [AW:0]        sum;
	logic [AW-1:0]      slot;
	logic [AW-1:0]      addr;
	logic               accept;
	logic               full;
	logic               empty;
	logic               in_range;
	logic               ok;
	logic               mem_en;
	logic               mem_we;
	logic [AW-1:0]      front_d;
	logic [FW-1:0]      fill_d;
	logic [DATA_W-1:0]  rdata;

	assign kind     = kind_t'(s_axis_tuser);
	assign position = s_axis_tdata[5:0];
	assign data_in  = s_axis_tdata[37:6];

	assign s_axis_tready = !rd_pend_s1 && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign pos_p    = PW'(position);
	assign fill_p   = PW'(fill_q);
	assign full     = (fill_q == DEPTH_F);
	assign empty    = (fill_q == '0);
	assign in_range = (pos_p < fill_p);

	// ring slot of front + offset; offset is below DEPTH when used
	always_comb begin
		if (kind == KIND_PUSH_BACK) begin
			sum = {1'b0, front_q} + (AW + 1)'(fill_q);
		end else begin
			sum = {1'b0, front_q} + pos_p[AW:0];
		end
		if (sum >= DEPTH_S) begin
			slot = AW'(sum - DEPTH_S);
		end else begin
			slot = sum[AW-1:0];
		end
	end

	always_comb begin
		ok      = 1'b0;
		mem_en  = 1'b0;
		mem_we  = 1'b0;
		addr    = slot;
		front_d = front_q;
		fill_d  = fill_q;
		case (kind)
			KIND_PUSH_BACK: begin
				ok     = !full;
				mem_en = !full;
				mem_we = 1'b1;
				fill_d = full ? fill_q : fill_q + 1'b1;
			end
			KIND_PUSH_FRONT: begin
				ok      = !full;
				mem_en  = !full;
				mem_we  = 1'b1;
				front_d = full ? front_q : ((front_q == '0) ? LAST_A : front_q - 1'b1);
				addr    = front_d;
				fill_d  = full ? fill_q : fill_q + 1'b1;
			end
			KIND_POP_BACK: begin
				ok     = !empty;
				fill_d = empty ? fill_q : fill_q - 1'b1;
			end
			KIND_POP_FRONT: begin
				ok      = !empty;
				front_d = empty ? front_q : ((front_q == LAST_A) ? '0 : front_q + 1'b1);
				fill_d  = empty ? fill_q : fill_q - 1'b1;
			end
			KIND_READ: begin
				ok     = in_range;
				mem_en = in_range;
			end
			KIND_WRITE: begin
				ok     = in_range;
				mem_en = in_range;
				mem_we = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	ids_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (accept && mem_en),
		.we   (mem_we),
		.addr (addr),
		.wdata(data_in),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			fill_q      <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= accept && mem_en && !mem_we;
			if (accept) begin
				front_q <= front_d;
				fill_q  <= fill_d;
			end
			if (rd_pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (accept) begin
				out_valid_q <= !(mem_en && !mem_we);
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_q.read_data <= rdata;
		end else if (accept) begin
			out_q.ok        <= ok;
			out_q.read_data <= '0;
			out_q.count     <= COUNT_W'(fill_d);
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tuser[0] = out_q.ok;
	assign m_axis_tdata    = {1'b0, out_q.count, out_q.read_data};

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_F)
		else $error("fill exceeds depth");

	a_read_pend: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_READ && in_range |=> rd_pend_s1)
		else $error("successful read did not start a RAM read");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !out_valid_q)
		else $error("read data returned into an occupied output register");

	a_no_accept_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !s_axis_tready && $stable(fill_q) && $stable(front_q))
		else $error("state moved while a read was in flight");
`endif

endmodule

`default_nettype wire
